// ===== sv/mflc_pkg.sv =====
// ----------------------------------------------------------------------------
// mflc_pkg
// Shared types, constants and the fault table lookup for the multiframe
// fault list commit block.
// ----------------------------------------------------------------------------
package mflc_pkg;

  // Fault table geometry
  localparam int TABLE_SIZE = 86;
  localparam int TBL_W      = 7;
  localparam int IDX_W      = 8;
  localparam int CODE_W     = 16;
  localparam int EVT_W      = 3;
  localparam int CNT_W      = 7;
  localparam int LOG_W      = 32;

  // Result event codes
  localparam logic [EVT_W-1:0] EV_STORED    = 3'd0;
  localparam logic [EVT_W-1:0] EV_IGNORED   = 3'd1;
  localparam logic [EVT_W-1:0] EV_CLEARED   = 3'd2;
  localparam logic [EVT_W-1:0] EV_COMMITTED = 3'd3;
  localparam logic [EVT_W-1:0] EV_GAP       = 3'd4;

  // Result of mapping a fault code onto a table slot
  typedef struct packed {
    logic             hit;
    logic [TBL_W-1:0] idx;
  } lookup_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;        // accept a request
    logic             scan;        // read list slot idx
    logic             set_gap;     // list has a hole, report rejection
    logic             walk_init;   // start the table walk
    logic             walk;        // update table entry idx
    logic             commit_end;  // last table entry, close the commit
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scan;  // request is the last frame of a valid list
    logic scan_last;  // idx addresses the last slot of the list
    logic gap;        // a slot below the total was empty
  } dp_status_t;

  // Fault table, stored as runs of consecutive codes. The final table entry
  // holds code zero and is never matched.
  function automatic lookup_t rom_lookup(input logic [CODE_W-1:0] code);
    lookup_t r;
    r = '0;
    if (code >= 16'd101 && code <= 16'd108) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd101);
    end else if (code >= 16'd151 && code <= 16'd153) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd151) + 7'd8;
    end else if (code == 16'd181) begin
      r.hit = 1'b1;
      r.idx = 7'd11;
    end else if (code >= 16'd201 && code <= 16'd216) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd201) + 7'd12;
    end else if (code >= 16'd251 && code <= 16'd254) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd251) + 7'd28;
    end else if (code >= 16'd281 && code <= 16'd284) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd281) + 7'd32;
    end else if (code >= 16'd301 && code <= 16'd320) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd301) + 7'd36;
    end else if (code >= 16'd351 && code <= 16'd374) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd351) + 7'd56;
    end else if (code >= 16'd381 && code <= 16'd385) begin
      r.hit = 1'b1;
      r.idx = TBL_W'(code - 16'd381) + 7'd80;
    end
    return r;
  endfunction

endpackage

// ===== sv/mflc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mflc_ctrl
// Sequencer: accepts requests, walks the list buffer for the gap check and
// hit collection, then walks the fault table to commit.
// ----------------------------------------------------------------------------
module mflc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mflc_pkg::dp_status_t status,
  output mflc_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    TAIL,
    CHECK,
    WALK
  } state_t;

  state_t                       state;
  logic [mflc_pkg::IDX_W-1:0]   idx;
  logic                         walk_last;

  assign walk_last = (idx == mflc_pkg::IDX_W'(mflc_pkg::TABLE_SIZE - 1));

  // Commands decoded from state
  always_comb begin
    cmd            = '0;
    cmd.idx        = idx;
    cmd.load       = start && !busy;
    cmd.scan       = (state == SCAN);
    cmd.set_gap    = (state == CHECK) && status.gap;
    cmd.walk_init  = (state == CHECK) && !status.gap;
    cmd.walk       = (state == WALK);
    cmd.commit_end = (state == WALK) && walk_last;
  end

  // State, index counter and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            if (status.need_scan) begin
              state <= SCAN;
              idx   <= '0;
              busy  <= 1'b1;
            end else begin
              done <= 1'b1;
            end
          end
        end
        SCAN: begin
          if (status.scan_last) begin
            state <= TAIL;
            idx   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // last slot read still in flight
        TAIL: begin
          state <= CHECK;
        end
        CHECK: begin
          if (status.gap) begin
            state <= IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= WALK;
            idx   <= '0;
          end
        end
        WALK: begin
          if (walk_last) begin
            state <= IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/mflc_dp.sv =====
// ----------------------------------------------------------------------------
// mflc_dp
// Datapath: list buffer memory with per-slot occupancy bits, hit collection,
// fault active flags and the event counters.
// ----------------------------------------------------------------------------
module mflc_dp #(
  parameter int MAX_FAULTS = 86
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mflc_pkg::dp_cmd_t                cmd,
  output mflc_pkg::dp_status_t             status,
  input  logic [7:0]                       total_count,
  input  logic [7:0]                       frame_index,
  input  logic [mflc_pkg::CODE_W-1:0]      fault_code,
  output logic [mflc_pkg::EVT_W-1:0]       event_kind,
  output logic [mflc_pkg::CNT_W-1:0]       active_count,
  output logic [mflc_pkg::CNT_W-1:0]       newly_active,
  output logic [mflc_pkg::LOG_W-1:0]       logged_total
);

  localparam int         SLOT_W = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;
  localparam logic [7:0] LIMIT  = 8'(MAX_FAULTS);

  logic [mflc_pkg::CODE_W-1:0]     mem [MAX_FAULTS];
  logic [MAX_FAULTS-1:0]           nz;         // slot holds a non-zero code
  logic [mflc_pkg::TABLE_SIZE-1:0] fault_active;
  logic [mflc_pkg::TABLE_SIZE-1:0] hit;
  logic [mflc_pkg::CODE_W-1:0]     rd_data;
  logic                            rd_nz;
  logic                            rd_valid;
  logic                            gap;
  logic [7:0]                      total_q;

  logic                            total_ok;
  logic                            frame_ok;
  logic                            do_store;
  logic [7:0]                      frame_m1;
  logic [SLOT_W-1:0]               slot_wr;
  logic [SLOT_W-1:0]               slot_rd;
  logic [mflc_pkg::TBL_W-1:0]      tbl;
  mflc_pkg::lookup_t               lk;

  // Request classification
  assign total_ok = (total_count != 8'd0) && (total_count <= LIMIT);
  assign frame_ok = (frame_index != 8'd0) && (frame_index <= LIMIT);
  assign do_store = cmd.load && total_ok && frame_ok;
  assign frame_m1 = frame_index - 8'd1;
  assign slot_wr  = frame_m1[SLOT_W-1:0];
  assign slot_rd  = cmd.idx[SLOT_W-1:0];
  assign tbl      = cmd.idx[mflc_pkg::TBL_W-1:0];
  assign lk       = mflc_pkg::rom_lookup(rd_data);

  assign status.need_scan = total_ok && frame_ok && (frame_index == total_count);
  assign status.scan_last = (cmd.idx == total_q - 8'd1);
  assign status.gap       = gap;

  // List buffer memory, registered read
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[slot_wr] <= fault_code;
    end
    if (cmd.scan) begin
      rd_data <= mem[slot_rd];
      rd_nz   <= nz[slot_rd];
    end
  end

  // Occupancy, hits, active flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      nz           <= '0;
      fault_active <= '0;
      hit          <= '0;
      gap          <= 1'b0;
      rd_valid     <= 1'b0;
      total_q      <= '0;
      event_kind   <= mflc_pkg::EV_STORED;
      active_count <= '0;
      newly_active <= '0;
      logged_total <= '0;
    end else begin
      rd_valid <= cmd.scan;

      // request entry
      if (cmd.load) begin
        total_q      <= total_count;
        newly_active <= '0;
        hit          <= '0;
        gap          <= 1'b0;
        if (!total_ok) begin
          nz           <= '0;
          fault_active <= '0;
          active_count <= '0;
          event_kind   <= mflc_pkg::EV_CLEARED;
        end else if (!frame_ok) begin
          event_kind <= mflc_pkg::EV_IGNORED;
        end else begin
          nz[slot_wr] <= (fault_code != '0);
          event_kind  <= mflc_pkg::EV_STORED;
        end
      end

      // list scan: empty slot marks a gap, known codes mark table hits
      if (rd_valid) begin
        if (!rd_nz) begin
          gap <= 1'b1;
        end else if (lk.hit) begin
          hit[lk.idx] <= 1'b1;
        end
      end

      if (cmd.set_gap) begin
        event_kind <= mflc_pkg::EV_GAP;
      end

      if (cmd.walk_init) begin
        active_count <= '0;
        newly_active <= '0;
      end

      // table walk: one entry per cycle
      if (cmd.walk) begin
        fault_active[tbl] <= hit[tbl];
        if (hit[tbl]) begin
          active_count <= active_count + 1'b1;
          if (!fault_active[tbl]) begin
            newly_active <= newly_active + 1'b1;
            logged_total <= logged_total + 1'b1;
          end
        end
      end

      if (cmd.commit_end) begin
        nz         <= '0;
        event_kind <= mflc_pkg::EV_COMMITTED;
      end
    end
  end

endmodule

// ===== sv/multiframe_fault_list_commit_top.sv =====
// ----------------------------------------------------------------------------
// multiframe_fault_list_commit_top
// Collects a fault list spread over several frames and commits it against a
// fixed table of 86 entries, 85 of them fault codes.
// ----------------------------------------------------------------------------
// Usage:
//   A request (total_count, frame_index, fault_code) is taken at a rising edge
//   with start high and busy low. Each request yields exactly one result on
//   event_kind, active_count, newly_active and logged_total, valid for the
//   single cycle in which done is high; the receiver cannot stall it.
//   Requests that clear, are ignored or only store a code: done is high in
//   the cycle after the request, busy stays low, so one request per cycle.
//   Last frame of a list: the list buffer is read one slot per cycle, then the
//   table is walked one entry per cycle.
//   After the scan the sequencer passes TAIL and CHECK; a gap rejects the
//   commit there with done, else the table walk follows and done rises after
//   its last entry; busy is high until the cycle in which done rises.
//   Reset clears the active flags, the buffer occupancy bits and the counters
//   at once; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module multiframe_fault_list_commit_top #(
  parameter int MAX_FAULTS = 86
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [7:0]                  total_count,
  input  logic [7:0]                  frame_index,
  input  logic [mflc_pkg::CODE_W-1:0] fault_code,
  output logic                        busy,
  output logic                        done,
  output logic [mflc_pkg::EVT_W-1:0]  event_kind,
  output logic [mflc_pkg::CNT_W-1:0]  active_count,
  output logic [mflc_pkg::CNT_W-1:0]  newly_active,
  output logic [mflc_pkg::LOG_W-1:0]  logged_total
);

  mflc_pkg::dp_cmd_t    cmd;
  mflc_pkg::dp_status_t status;

  mflc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mflc_dp #(
    .MAX_FAULTS (MAX_FAULTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .total_count  (total_count),
    .frame_index  (frame_index),
    .fault_code   (fault_code),
    .event_kind   (event_kind),
    .active_count (active_count),
    .newly_active (newly_active),
    .logged_total (logged_total)
  );

  // Result is only presented once the sequencer is free again
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Active count never exceeds the table size
  a_active_range: assert property (@(posedge clk) disable iff (rst)
    active_count <= mflc_pkg::CNT_W'(mflc_pkg::TABLE_SIZE))
    else $error("active count out of range");

  // Only a commit reports new activations
  a_newly_commit: assert property (@(posedge clk) disable iff (rst)
    done && (event_kind != mflc_pkg::EV_COMMITTED) |-> (newly_active == '0))
    else $error("activations reported outside a commit");

  // A zero total clears in the next cycle
  a_clear_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (total_count == 8'd0) |=>
      done && (event_kind == mflc_pkg::EV_CLEARED) && (active_count == '0))
    else $error("clear request not reported in time");

endmodule

// ===== sim/multiframe_fault_list_commit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiframe_fault_list_commit_top_tb
// Self-checking bench for the multiframe fault list commit block. A directed
// table walks the clear, ignore, gap and commit cases, then random fault lists
// (mostly complete, some with holes, stray frames or noise) run through three
// sender idle phases. Results are checked against a behavioral predictor or a typed row.
// ----------------------------------------------------------------------------
module multiframe_fault_list_commit_top_tb;

  localparam int MAX_FRAMES     = 86;
  localparam int ITEM_TARGET    = 1700;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [mflc_pkg::EVT_W-1:0] kind;
    logic [mflc_pkg::CNT_W-1:0] active;
    logic [mflc_pkg::CNT_W-1:0] fresh;
    logic [mflc_pkg::LOG_W-1:0] logged;
  } frame_result_t;

  typedef struct {
    logic [7:0]                  total;
    logic [7:0]                  frame;
    logic [mflc_pkg::CODE_W-1:0] code;
    bit                          typed;
    frame_result_t               res;
  } directed_row_t;

  // DUT ports
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [7:0]                  total_count = '0;
  logic [7:0]                  frame_index = '0;
  logic [mflc_pkg::CODE_W-1:0] fault_code = '0;
  logic                        busy;
  logic                        done;
  logic [mflc_pkg::EVT_W-1:0]  event_kind;
  logic [mflc_pkg::CNT_W-1:0]  active_count;
  logic [mflc_pkg::CNT_W-1:0]  newly_active;
  logic [mflc_pkg::LOG_W-1:0]  logged_total;

  // Typed expectation travelling with a directed request
  bit            req_typed = 1'b0;
  frame_result_t req_result = '0;

  // Predictor state
  logic [mflc_pkg::CODE_W-1:0] fault_codes [mflc_pkg::TABLE_SIZE];
  logic [mflc_pkg::CODE_W-1:0] list_slots [MAX_FRAMES];
  bit                          active_flags [mflc_pkg::TABLE_SIZE];
  logic [mflc_pkg::LOG_W-1:0]  activations;
  int                          code_fill;

  frame_result_t pending_results [$];
  directed_row_t directed_rows [$];
  int            seen_events [8];
  int            errors = 0;
  int            quiet_cycles = 0;
  int            frames_sent = 0;
  int            gap_pct = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multiframe_fault_list_commit_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .total_count  (total_count),
    .frame_index  (frame_index),
    .fault_code   (fault_code),
    .busy         (busy),
    .done         (done),
    .event_kind   (event_kind),
    .active_count (active_count),
    .newly_active (newly_active),
    .logged_total (logged_total)
  );

  task automatic add_code_run(input int first, input int len);
    for (int i = 0; i < len; i++) begin
      fault_codes[code_fill] = mflc_pkg::CODE_W'(first + i);
      code_fill++;
    end
  endtask

  // Fault code table and predictor reset state
  initial begin : load_codes
    code_fill = 0;
    add_code_run(101, 8);
    add_code_run(151, 3);
    add_code_run(181, 1);
    add_code_run(201, 16);
    add_code_run(251, 4);
    add_code_run(281, 4);
    add_code_run(301, 20);
    add_code_run(351, 24);
    add_code_run(381, 5);
    fault_codes[mflc_pkg::TABLE_SIZE-1] = '0;  // unused entry, never matched
    foreach (list_slots[i]) list_slots[i] = '0;
    foreach (active_flags[i]) active_flags[i] = 1'b0;
    foreach (seen_events[i]) seen_events[i] = 0;
    activations = '0;
  end

  // Applies one frame to the predictor state and returns its result
  function automatic frame_result_t predict_frame(
      input logic [7:0] total,
      input logic [7:0] frame,
      input logic [mflc_pkg::CODE_W-1:0] code);
    frame_result_t r;
    bit            hole;
    bit            hit;
    int            n_active;
    int            n_fresh;
    r = '0;
    n_active = 0;
    n_fresh = 0;
    if (total == 0 || total > MAX_FRAMES) begin
      foreach (list_slots[i]) list_slots[i] = '0;
      foreach (active_flags[i]) active_flags[i] = 1'b0;
      r.kind = mflc_pkg::EV_CLEARED;
    end else if (frame == 0 || frame > MAX_FRAMES) begin
      r.kind = mflc_pkg::EV_IGNORED;
    end else begin
      list_slots[frame-1] = code;
      r.kind = mflc_pkg::EV_STORED;
      if (frame == total) begin
        hole = 1'b0;
        for (int j = 0; j < total; j++)
          if (list_slots[j] == '0) hole = 1'b1;
        if (hole) begin
          r.kind = mflc_pkg::EV_GAP;
        end else begin
          // table walk: an entry is active exactly when its code is listed
          for (int i = 0; i < mflc_pkg::TABLE_SIZE; i++) begin
            hit = 1'b0;
            for (int j = 0; j < total; j++)
              if (list_slots[j] == fault_codes[i]) hit = 1'b1;
            if (hit && !active_flags[i]) begin
              n_fresh++;
              activations++;
            end
            active_flags[i] = hit;
          end
          foreach (list_slots[i]) list_slots[i] = '0;
          r.kind = mflc_pkg::EV_COMMITTED;
        end
      end
    end
    foreach (active_flags[i]) if (active_flags[i]) n_active++;
    r.active = mflc_pkg::CNT_W'(n_active);
    r.fresh  = mflc_pkg::CNT_W'(n_fresh);
    r.logged = activations;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [mflc_pkg::LOG_W-1:0] want,
                             input logic [mflc_pkg::LOG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checking, request capture and watchdog
  always @(posedge clk) begin : monitor
    frame_result_t want;
    bit            taken;
    if (!rst) begin
      taken = start && !busy;
      if (done) begin
        if (!$isunknown(event_kind)) seen_events[event_kind]++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending, event_kind %0d",
                   $time, event_kind);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_kind", mflc_pkg::LOG_W'(want.kind),
                      mflc_pkg::LOG_W'(event_kind));
          check_field("active_count", mflc_pkg::LOG_W'(want.active),
                      mflc_pkg::LOG_W'(active_count));
          check_field("newly_active", mflc_pkg::LOG_W'(want.fresh),
                      mflc_pkg::LOG_W'(newly_active));
          check_field("logged_total", want.logged, logged_total);
        end
      end
      if (taken) begin
        want = predict_frame(total_count, frame_index, fault_code);
        if (req_typed) want = req_result;
        pending_results.push_back(want);
      end
      if (done || taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Presents one request, at times with a random idle gap ahead of it
  task automatic send_frame(input logic [7:0] total, input logic [7:0] frame,
                            input logic [mflc_pkg::CODE_W-1:0] code, input bit typed,
                            input frame_result_t res);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start       <= 1'b1;
    total_count <= total;
    frame_index <= frame;
    fault_code  <= code;
    req_typed   <= typed;
    req_result  <= res;
    do @(posedge clk); while (busy);
    if (!(total != 0 && total <= MAX_FRAMES && (frame == 0 || frame > MAX_FRAMES)))
      frames_sent++;
  endtask

  // Sender holds off until every result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] total, input logic [7:0] frame,
                         input logic [mflc_pkg::CODE_W-1:0] code, input bit typed,
                         input frame_result_t res);
    directed_row_t row;
    row.total = total;
    row.frame = frame;
    row.code  = code;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  function automatic logic [mflc_pkg::CODE_W-1:0] pick_code();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return mflc_pkg::CODE_W'($urandom);
    if (sel == 1) return mflc_pkg::CODE_W'($urandom_range(400, 1));
    return fault_codes[$urandom_range(mflc_pkg::TABLE_SIZE-2, 0)];
  endfunction

  // Mostly short lists, a few long ones, rarely the full table
  function automatic int pick_total();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 70) return $urandom_range(6, 1);
    if (sel < 92) return $urandom_range(24, 7);
    if (sel < 97) return $urandom_range(MAX_FRAMES-1, 25);
    return MAX_FRAMES;
  endfunction

  // One random fault list: complete, with a hole, with a stray frame, or noise
  task automatic run_list();
    int total;
    int shape;
    int missing;
    int rot;
    logic [mflc_pkg::CODE_W-1:0] code;
    total = pick_total();
    shape = $urandom_range(9, 0);
    rot = $urandom_range(mflc_pkg::TABLE_SIZE-2, 0);
    if (shape == 9) begin
      if ($urandom_range(9, 0) < 4)
        send_frame($urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, 87)),
                   8'($urandom), mflc_pkg::CODE_W'($urandom), 1'b0, '0);
      else
        send_frame(8'(total), $urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, 87)),
                   mflc_pkg::CODE_W'($urandom), 1'b0, '0);
    end else begin
      missing = (shape == 7 && total > 1) ? $urandom_range(total-1, 1) : 0;
      for (int f = 1; f <= total; f++) begin
        // stray frame above the total, ahead of the last one
        if (f == total && shape == 8 && total < MAX_FRAMES)
          send_frame(8'(total), 8'($urandom_range(MAX_FRAMES, total+1)), pick_code(),
                     1'b0, '0);
        if (total >= 20 && rot[0])
          code = fault_codes[(f-1+rot) % (mflc_pkg::TABLE_SIZE-1)];
        else code = pick_code();
        if (f != missing) send_frame(8'(total), 8'(f), code, 1'b0, '0);
      end
      // fill the hole and resend the last frame
      if (missing != 0 && $urandom_range(1, 0)) begin
        send_frame(8'(total), 8'(missing),
                   fault_codes[$urandom_range(mflc_pkg::TABLE_SIZE-2, 0)], 1'b0, '0);
        send_frame(8'(total), 8'(total), pick_code(), 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    int phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table; typed results only where the outcome is obvious
    add_row(8'd1,   8'd0,   16'h0000, 1'b1, {mflc_pkg::EV_IGNORED,   7'd0, 7'd0, 32'd0});
    add_row(8'd0,   8'd5,   16'hFFFF, 1'b1, {mflc_pkg::EV_CLEARED,   7'd0, 7'd0, 32'd0});
    add_row(8'd255, 8'd255, 16'hFFFF, 1'b1, {mflc_pkg::EV_CLEARED,   7'd0, 7'd0, 32'd0});
    add_row(8'd87,  8'd1,   16'd101,  1'b1, {mflc_pkg::EV_CLEARED,   7'd0, 7'd0, 32'd0});
    add_row(8'd86,  8'd87,  16'hFFFF, 1'b1, {mflc_pkg::EV_IGNORED,   7'd0, 7'd0, 32'd0});
    add_row(8'd86,  8'd255, 16'h5555, 1'b1, {mflc_pkg::EV_IGNORED,   7'd0, 7'd0, 32'd0});
    add_row(8'd1,   8'd1,   16'h0000, 1'b1, {mflc_pkg::EV_GAP,       7'd0, 7'd0, 32'd0});
    add_row(8'd1,   8'd1,   16'd101,  1'b1, {mflc_pkg::EV_COMMITTED, 7'd1, 7'd1, 32'd1});
    add_row(8'd1,   8'd1,   16'd101,  1'b1, {mflc_pkg::EV_COMMITTED, 7'd1, 7'd0, 32'd1});
    add_row(8'd2,   8'd3,   16'd385,  1'b0, '0);  // beyond the total
    add_row(8'd2,   8'd2,   16'h1234, 1'b0, '0);  // hole in slot 0
    add_row(8'd2,   8'd1,   16'd385,  1'b0, '0);
    add_row(8'd2,   8'd2,   16'hFFFF, 1'b0, '0);  // commit, 101 drops out
    add_row(8'd86,  8'd86,  16'hFFFF, 1'b0, '0);  // last frame of a full list
    add_row(8'd3,   8'd86,  16'hAAAA, 1'b0, '0);  // top slot
    add_row(8'd3,   8'd1,   16'd181,  1'b0, '0);
    add_row(8'd3,   8'd2,   16'h0000, 1'b0, '0);
    add_row(8'd3,   8'd3,   16'd374,  1'b0, '0);  // zero slot rejects
    add_row(8'd3,   8'd2,   16'd101,  1'b0, '0);
    add_row(8'd3,   8'd3,   16'd374,  1'b0, '0);
    add_row(8'd1,   8'd1,   16'hFFFF, 1'b0, '0);  // code not in the table
    add_row(8'd0,   8'd0,   16'h0000, 1'b0, '0);
    foreach (directed_rows[i])
      send_frame(directed_rows[i].total, directed_rows[i].frame, directed_rows[i].code,
                 directed_rows[i].typed, directed_rows[i].res);
    drain();

    // random lists: no idling, sender idle 60 of 100, sender idle 27 of 100
    for (int p = 0; p < 3; p++) begin
      gap_pct = (p == 1) ? 60 : (p == 2) ? 27 : 0;
      phase_end = frames_sent + ITEM_TARGET / 3;
      while (frames_sent < phase_end) run_list();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d counted requests (%0d directed) over three sender idle phases",
             frames_sent, directed_rows.size());
    $display("Results: %0d stored, %0d ignored, %0d cleared, %0d committed, %0d gap",
             seen_events[mflc_pkg::EV_STORED], seen_events[mflc_pkg::EV_IGNORED],
             seen_events[mflc_pkg::EV_CLEARED], seen_events[mflc_pkg::EV_COMMITTED],
             seen_events[mflc_pkg::EV_GAP]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mflc_pkg.sv
sv/mflc_ctrl.sv
sv/mflc_dp.sv
sv/multiframe_fault_list_commit_top.sv
sim/multiframe_fault_list_commit_top_tb.sv
